>>> rtl/core/udt_pkg.sv
// Shared types and constants for the unique key dedup table.
package udt_pkg;

   localparam int unsigned KEY_PORT_BITS = 64;
   localparam int unsigned CNT_BITS      = 32;
   localparam logic [CNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [3:0] KEY_BYTES_RESET = 4'd8;
   localparam logic       REG_KEY_BYTES   = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_MISS,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        overflow;
      logic [10:0] unique_total;
      logic [31:0] occurrences;
      logic [31:0] first_index;
      logic [9:0]  unique_id;
      logic        is_new;
   } result_type;

endpackage

>>> rtl/core/udt_ram.sv
// Generic single-port-write, registered-read RAM.
module udt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/core/udt_engine.sv
// Lookup engine: scans the key table memory, updates it and builds the result.
module udt_engine #(
   parameter int unsigned TABLE_ENTRIES = 1024,
   parameter int unsigned KEY_BITS      = 64,
   parameter int unsigned INDEX_BITS    = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [3:0]               key_bytes,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [udt_pkg::KEY_PORT_BITS-1:0] in_key,
   input  logic                     in_last,
   output logic                     res_valid,
   input  logic                     res_ready,
   output udt_pkg::result_type      res
);
   import udt_pkg::*;

   localparam int unsigned AW = $clog2(TABLE_ENTRIES);
   localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
   localparam int unsigned EW = INDEX_BITS + CNT_BITS + KEY_BITS;

   state_type state_ff, state_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [KEY_BITS-1:0]   mask_ff, mask_in;
   logic                  last_ff, last_in;
   logic [AW-1:0]         scan_ff, scan_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [INDEX_BITS-1:0] pos_ff, pos_in;
   result_type            res_ff, res_in;
   logic                  we_ff, we_in;
   logic                  new_ff, new_in;
   logic [AW-1:0]         wr_addr_ff, wr_addr_in;
   logic [EW-1:0]         wr_data_ff, wr_data_in;

   logic [KEY_PORT_BITS-1:0] mask_full;
   logic [3:0]               nbytes;
   logic                     rd_en;
   logic [EW-1:0]            rd_data;
   logic [KEY_BITS-1:0]      rd_key;
   logic [CNT_BITS-1:0]      rd_cnt, cnt_inc;
   logic [INDEX_BITS-1:0]    rd_first;
   logic                     wr_en;

   // Compare mask from the byte count, clamped to 1..8 and to KEY_BITS.
   always_comb begin
      nbytes = key_bytes;
      if (nbytes == 4'd0) begin
         nbytes = 4'd1;
      end else if (nbytes > 4'd8) begin
         nbytes = 4'd8;
      end
      for (int b = 0; b < KEY_PORT_BITS; b++) begin
         mask_full[b] = (b < KEY_BITS) && ((b / 8) < int'(nbytes));
      end
   end

   assign rd_key   = rd_data[KEY_BITS-1:0];
   assign rd_cnt   = rd_data[KEY_BITS +: CNT_BITS];
   assign rd_first = rd_data[KEY_BITS+CNT_BITS +: INDEX_BITS];
   assign cnt_inc  = (rd_cnt != COUNT_MAX) ? rd_cnt + 1'b1 : rd_cnt;

   udt_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr_ff),
      .wr_data (wr_data_ff),
      .rd_en   (rd_en),
      .rd_addr (scan_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in   = state_ff;
      key_in     = key_ff;
      mask_in    = mask_ff;
      last_in    = last_ff;
      scan_in    = scan_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      res_in     = res_ff;
      we_in      = we_ff;
      new_in     = new_ff;
      wr_addr_in = wr_addr_ff;
      wr_data_in = wr_data_ff;
      in_ready   = 1'b0;
      res_valid  = 1'b0;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               key_in  = KEY_BITS'(in_key & mask_full);
               mask_in = KEY_BITS'(mask_full);
               last_in = in_last;
               scan_in = '0;
               state_in = (count_ff == '0) ? ST_MISS : ST_READ;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if ((rd_key & mask_ff) == key_ff) begin
               res_in.is_new       = 1'b0;
               res_in.unique_id    = 10'(scan_ff);
               res_in.first_index  = 32'(rd_first);
               res_in.occurrences  = cnt_inc;
               res_in.unique_total = 11'(count_ff);
               res_in.overflow     = 1'b0;
               we_in      = 1'b1;
               new_in     = 1'b0;
               wr_addr_in = scan_ff;
               wr_data_in = {rd_first, cnt_inc, rd_key};
               state_in   = ST_DONE;
            end else if (CW'(scan_ff) + 1'b1 == count_ff) begin
               state_in = ST_MISS;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_MISS: begin
            res_in.is_new      = 1'b1;
            res_in.first_index = 32'(pos_ff);
            if (count_ff < CW'(TABLE_ENTRIES)) begin
               res_in.unique_id    = 10'(count_ff);
               res_in.occurrences  = 32'd1;
               res_in.unique_total = 11'(count_ff + 1'b1);
               res_in.overflow     = 1'b0;
               we_in      = 1'b1;
               new_in     = 1'b1;
               wr_addr_in = AW'(count_ff);
               wr_data_in = {pos_ff, 32'd1, key_ff};
            end else begin
               // Table full: drop the key.
               res_in.unique_id    = '0;
               res_in.occurrences  = '0;
               res_in.unique_total = 11'(count_ff);
               res_in.overflow     = 1'b1;
               we_in  = 1'b0;
               new_in = 1'b0;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               wr_en    = we_ff;
               count_in = count_ff + CW'(new_ff);
               pos_in   = pos_ff + 1'b1;
               if (last_ff) begin
                  count_in = '0;
                  pos_in   = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
      end
      key_ff     <= key_in;
      mask_ff    <= mask_in;
      last_ff    <= last_in;
      scan_ff    <= scan_in;
      res_ff     <= res_in;
      we_ff      <= we_in;
      new_ff     <= new_in;
      wr_addr_ff <= wr_addr_in;
      wr_data_ff <= wr_data_in;
   end

   assign res = res_ff;
endmodule

>>> rtl/core/unique_key_dedup_table.sv
// Top level of the unique key dedup table: register port, engine, result register.
//
//  channel | direction | payload                                  | handshake
//  req_    | in        | tdata key, tlast last_item              | tvalid/tready
//  rsp_    | out       | tdata result fields (88 bits)           | tvalid/tready
//  csr_    | in/out    | key_bytes at address 0                  | APB, pready high
//
// An item goes through a read state and a compare state for each table entry
// scanned on the single table read port: up to and including the match on a hit,
// and all distinct keys so far, followed by the miss state, on a miss.
// Reset clears the fill count and position; the table memory needs no clear,
// since only entries below the fill count are ever read.
// A waiting result sits in the output register; the engine holds its next
// result until that register drains.
module unique_key_dedup_table #(
   parameter int unsigned TABLE_ENTRIES = 1024,
   parameter int unsigned KEY_BITS      = 64,
   parameter int unsigned INDEX_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] key
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] is_new, [10:1] unique_id, [42:11] first_index, [74:43] occurrences,
   // [85:75] unique_total, [86] overflow, [87] zero
   output logic [87:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import udt_pkg::*;

   logic [3:0]  key_bytes_ff, key_bytes_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff, rsp_data_in;
   logic        res_valid, res_ready;
   result_type  res;

   udt_engine #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .KEY_BITS      (KEY_BITS),
      .INDEX_BITS    (INDEX_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .key_bytes (key_bytes_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_key    (req_tdata),
      .in_last   (req_tlast),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      key_bytes_in = key_bytes_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && (csr_paddr[2] == REG_KEY_BYTES)) begin
         key_bytes_in = csr_pwdata[3:0];
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_bytes_ff <= KEY_BYTES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_bytes_ff <= key_bytes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_KEY_BYTES) ? {28'd0, key_bytes_ff} : 32'd0;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};
endmodule
